// ----- rtl/core/gtsp_pkg.sv -----
// gtsp_pkg: types, codes and constants of the generation tagged section pool
// no dependencies; used by the interfaces and every module of the pool
`timescale 1ns / 1ps

package gtsp_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_SLOTS = (POOL_SLOTS < 64) ? POOL_SLOTS : 64;
    localparam int ADDR_BITS  = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;

    localparam logic [47:0] USER_LAST_PAGE = 48'h7FFF_FFFF_F000;
    localparam logic [31:0] REFS_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_RESET    = 32'hFFFF_FFFF;

    localparam logic [31:0] PROT_READONLY     = 32'h02;
    localparam logic [31:0] PROT_EXECUTE      = 32'h10;
    localparam logic [31:0] PROT_EXECUTE_READ = 32'h20;

    typedef enum logic [3:0] {
        CMD_RESERVE     = 4'd0,
        CMD_ABORT       = 4'd1,
        CMD_PUBLISH     = 4'd2,
        CMD_RETAIN      = 4'd3,
        CMD_RELEASE     = 4'd4,
        CMD_RETIRE_DONE = 4'd5,
        CMD_VIEW_CHECK  = 4'd6,
        CMD_VIEW_COMMIT = 4'd7,
        CMD_QUERY       = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_KEY   = 3'd1,
        ST_WRONG     = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_SATURATED = 3'd4,
        ST_BAD_ADDR  = 3'd5,
        ST_WX        = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_FREE         = 2'd0,
        PH_CONSTRUCTING = 2'd1,
        PH_LIVE         = 2'd2,
        PH_RETIRING     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [5:0]  slot_index;
        logic [31:0] key_generation;
        logic [20:0] page_count;
        logic [31:0] protect_code;
        logic [47:0] view_base;
        logic        adopt_reference;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [5:0]  out_slot;
        logic [31:0] out_generation;
        logic [20:0] out_pages;
        logic        write_grant;
        logic        exec_grant;
        logic        write_history;
        logic        exec_history;
        logic        frames_to_free;
    } t_out;

    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] generation;
        logic [20:0] pages;
        logic [31:0] refs;
        logic        write_seen;
        logic        exec_seen;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic idx_clr;
        logic idx_inc;
        logic commit;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_reserve;
        logic scan_hit;
        logic scan_last;
    } t_sts;

    // protect code to {write, execute}
    function automatic logic [1:0] decode_protect(input logic [31:0] code);
        logic [1:0] wx;
        wx = 2'b10;
        if (code == PROT_READONLY) begin
            wx = 2'b00;
        end else if (code == PROT_EXECUTE || code == PROT_EXECUTE_READ) begin
            wx = 2'b01;
        end
        return wx;
    endfunction

endpackage

// ----- rtl/core/gtsp_in_if.sv -----
// gtsp_in_if: command channel, valid/ready with a command item
// depends on gtsp_pkg
`timescale 1ns / 1ps

interface gtsp_in_if;
    logic            valid;
    logic            ready;
    gtsp_pkg::t_in   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/gtsp_out_if.sv -----
// gtsp_out_if: result channel, valid/ready with a result item
// depends on gtsp_pkg
`timescale 1ns / 1ps

interface gtsp_out_if;
    logic            valid;
    logic            ready;
    gtsp_pkg::t_out  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/gtsp_dpath.sv -----
// gtsp_dpath: slot memory, scan index, command evaluation and result register
// depends on gtsp_pkg
`timescale 1ns / 1ps

module gtsp_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    input  gtsp_pkg::t_in        i_item,
    input  gtsp_pkg::t_ctl       i_ctl,
    output gtsp_pkg::t_sts       o_sts,
    output gtsp_pkg::t_out       o_result
);

    gtsp_pkg::t_entry r_mem [gtsp_pkg::ADDR_SLOTS];
    logic [gtsp_pkg::ADDR_SLOTS-1:0] r_vld;

    gtsp_pkg::t_in     r_item;
    gtsp_pkg::t_entry  r_rd_data;
    logic              r_rd_vld;
    logic [31:0]       r_limit;
    logic [gtsp_pkg::ADDR_BITS-1:0] r_idx;
    gtsp_pkg::t_out    r_out;

    logic [gtsp_pkg::ADDR_BITS-1:0] addr;
    logic              is_reserve;
    gtsp_pkg::t_entry  ent;
    gtsp_pkg::t_entry  n_ent;
    logic              wr_en;
    gtsp_pkg::t_out    n_out;
    gtsp_pkg::t_status st;
    logic              live;
    logic              hit;
    logic [1:0]        wx;
    logic [32:0]       last_off;
    logic [47:0]       room;

    assign is_reserve = (r_item.cmd == gtsp_pkg::CMD_RESERVE);
    assign addr = is_reserve ? r_idx : r_item.slot_index[gtsp_pkg::ADDR_BITS-1:0];
    assign ent  = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= gtsp_pkg::LIMIT_RESET;
            r_vld   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_ctl.commit && wr_en) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && wr_en) begin
            r_mem[addr] <= n_ent;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[addr];
            r_rd_vld  <= r_vld[addr];
        end
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.idx_clr) begin
            r_idx <= '0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_ctl.commit) begin
            r_out <= n_out;
        end
    end

    assign hit = (ent.phase == gtsp_pkg::PH_FREE) && (ent.generation < r_limit);
    assign live = (ent.phase == gtsp_pkg::PH_LIVE) && (ent.generation == r_item.key_generation)
                  && (ent.refs != '0);
    assign wx = gtsp_pkg::decode_protect(r_item.protect_code);
    assign last_off = {ent.pages - 21'd1, {gtsp_pkg::PAGE_SHIFT{1'b0}}};
    assign room = gtsp_pkg::USER_LAST_PAGE - r_item.view_base;

    always_comb begin
        n_out = '0;
        n_ent = ent;
        wr_en = 1'b0;
        st    = gtsp_pkg::ST_OK;
        if (is_reserve) begin
            if (hit) begin
                n_ent.phase      = gtsp_pkg::PH_CONSTRUCTING;
                n_ent.generation = ent.generation + 32'd1;
                n_ent.pages      = '0;
                n_ent.refs       = '0;
                n_ent.write_seen = 1'b0;
                n_ent.exec_seen  = 1'b0;
                wr_en = 1'b1;
                n_out.out_slot       = 6'(r_idx);
                n_out.out_generation = ent.generation + 32'd1;
            end else begin
                st = gtsp_pkg::ST_EXHAUSTED;
            end
        end else if (r_item.cmd > gtsp_pkg::CMD_QUERY) begin
            st = gtsp_pkg::ST_WRONG;
        end else if (32'(r_item.slot_index) >= gtsp_pkg::ADDR_SLOTS) begin
            st = gtsp_pkg::ST_BAD_KEY;
        end else begin
            if (r_item.cmd == gtsp_pkg::CMD_QUERY) begin
                n_out.out_slot       = r_item.slot_index;
                n_out.out_generation = ent.generation;
            end
            if (r_item.key_generation == '0) begin
                st = gtsp_pkg::ST_BAD_KEY;
            end else begin
                case (r_item.cmd)
                    gtsp_pkg::CMD_ABORT: begin
                        if (ent.phase != gtsp_pkg::PH_CONSTRUCTING ||
                            ent.generation != r_item.key_generation) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_ent.phase = gtsp_pkg::PH_FREE;
                            wr_en = 1'b1;
                        end
                    end
                    gtsp_pkg::CMD_PUBLISH: begin
                        if (ent.phase != gtsp_pkg::PH_CONSTRUCTING ||
                            ent.generation != r_item.key_generation) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_ent.pages      = r_item.page_count;
                            n_ent.refs       = 32'd1;
                            n_ent.write_seen = 1'b0;
                            n_ent.exec_seen  = 1'b0;
                            n_ent.phase      = gtsp_pkg::PH_LIVE;
                            wr_en = 1'b1;
                        end
                    end
                    gtsp_pkg::CMD_RETAIN: begin
                        if (!live) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else if (ent.refs == gtsp_pkg::REFS_MAX) begin
                            st = gtsp_pkg::ST_SATURATED;
                        end else begin
                            n_ent.refs = ent.refs + 32'd1;
                            wr_en = 1'b1;
                        end
                    end
                    gtsp_pkg::CMD_RELEASE: begin
                        if (!live) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_ent.refs = ent.refs - 32'd1;
                            wr_en = 1'b1;
                            if (ent.refs == 32'd1) begin
                                n_ent.phase      = gtsp_pkg::PH_RETIRING;
                                n_ent.pages      = '0;
                                n_ent.write_seen = 1'b0;
                                n_ent.exec_seen  = 1'b0;
                                n_out.frames_to_free = 1'b1;
                            end
                        end
                    end
                    gtsp_pkg::CMD_RETIRE_DONE: begin
                        if (ent.phase != gtsp_pkg::PH_RETIRING ||
                            ent.generation != r_item.key_generation) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_ent.phase = gtsp_pkg::PH_FREE;
                            wr_en = 1'b1;
                        end
                    end
                    gtsp_pkg::CMD_QUERY: begin
                        if (!live) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_out.out_pages     = ent.pages;
                            n_out.write_history = ent.write_seen;
                            n_out.exec_history  = ent.exec_seen;
                        end
                    end
                    default: begin
                        // view check and view commit
                        n_out.write_grant = wx[1];
                        n_out.exec_grant  = wx[0];
                        if (r_item.view_base[gtsp_pkg::PAGE_SHIFT-1:0] != '0) begin
                            st = gtsp_pkg::ST_BAD_ADDR;
                        end else if (!live) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else if (ent.refs == gtsp_pkg::REFS_MAX) begin
                            st = gtsp_pkg::ST_SATURATED;
                        end else if (ent.pages == '0) begin
                            st = gtsp_pkg::ST_WRONG;
                        end else begin
                            n_out.out_pages     = ent.pages;
                            n_out.write_history = ent.write_seen;
                            n_out.exec_history  = ent.exec_seen;
                            if (r_item.view_base > gtsp_pkg::USER_LAST_PAGE ||
                                48'(last_off) > room) begin
                                st = gtsp_pkg::ST_BAD_ADDR;
                            end else if ((wx[0] && ent.write_seen) ||
                                         (wx[1] && ent.exec_seen)) begin
                                st = gtsp_pkg::ST_WX;
                            end else if (r_item.cmd == gtsp_pkg::CMD_VIEW_COMMIT) begin
                                n_ent.write_seen = ent.write_seen | wx[1];
                                n_ent.exec_seen  = ent.exec_seen | wx[0];
                                n_ent.refs = ent.refs + 32'(r_item.adopt_reference);
                                wr_en = 1'b1;
                                n_out.write_history = ent.write_seen | wx[1];
                                n_out.exec_history  = ent.exec_seen | wx[0];
                            end
                        end
                    end
                endcase
            end
        end
        n_out.status = st;
        n_out.ok     = (st == gtsp_pkg::ST_OK);
    end

    assign o_sts.is_reserve = is_reserve;
    assign o_sts.scan_hit   = hit;
    assign o_sts.scan_last  = (32'(r_idx) == gtsp_pkg::ADDR_SLOTS - 1);
    assign o_result = r_out;

endmodule

// ----- rtl/core/gtsp_ctrl.sv -----
// gtsp_ctrl: command sequencer and result valid flag
// depends on gtsp_pkg
`timescale 1ns / 1ps

module gtsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  gtsp_pkg::t_sts  i_sts,
    output gtsp_pkg::t_ctl  o_ctl
);

    gtsp_pkg::t_state r_state;
    gtsp_pkg::t_state n_state;
    logic             r_out_valid;
    logic             out_busy;
    logic             scan_more;

    assign out_busy  = r_out_valid && !i_out_ready;
    assign scan_more = i_sts.is_reserve && !i_sts.scan_hit && !i_sts.scan_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtsp_pkg::S_IDLE: if (i_in_valid) n_state = gtsp_pkg::S_READ;
            gtsp_pkg::S_READ: n_state = gtsp_pkg::S_EVAL;
            gtsp_pkg::S_EVAL: begin
                if (scan_more) begin
                    n_state = gtsp_pkg::S_READ;
                end else if (!out_busy) begin
                    n_state = gtsp_pkg::S_IDLE;
                end
            end
            default: n_state = gtsp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gtsp_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.load    = i_in_valid;
                o_ctl.idx_clr = i_in_valid;
            end
            gtsp_pkg::S_READ: o_ctl.rd = 1'b1;
            gtsp_pkg::S_EVAL: begin
                o_ctl.idx_inc = scan_more;
                o_ctl.commit  = !scan_more && !out_busy;
            end
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtsp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |=> r_out_valid)
        else $error("result not presented after commit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.commit && r_out_valid && !i_out_ready))
        else $error("pending result overwritten");

    a_scan_only_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.idx_inc |-> i_sts.is_reserve)
        else $error("slot scan advanced outside reserve");

    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == gtsp_pkg::S_READ))
        else $error("accepted item not read");

endmodule

// ----- rtl/core/generation_tagged_section_pool_core.sv -----
// generation_tagged_section_pool_core: top level of the section pool
// depends on gtsp_pkg, gtsp_in_if, gtsp_out_if, gtsp_ctrl, gtsp_dpath
`timescale 1ns / 1ps

// usage
//   i_in carries one command item per valid/ready handshake; o_out returns
//   exactly one result item for each command, in order
//   i_cfg_we/i_cfg_data write generation_limit; write only while idle
// sequence
//   a slot command reads its slot from the slot memory and evaluates it:
//   accept, read, evaluate and commit, in that order; the result is presented
//   from the commit edge on; a new command is accepted only after the commit
//   reserve scans the slots one per read/evaluate pair of the single
//   memory port, from slot zero up to the granted slot, or through all
//   64 slots when the pool is exhausted
// reset
//   synchronous active low; every slot reads free with generation zero
//   through per-slot valid bits, no clearing pass; limit returns to all ones
// stalls
//   the result register holds an item until taken; the next command is
//   accepted meanwhile and waits at commit while the register is full

module generation_tagged_section_pool_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gtsp_in_if.sink      i_in,
    gtsp_out_if.source   o_out,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_data
);

    gtsp_pkg::t_ctl ctl;
    gtsp_pkg::t_sts sts;

    // sequencer: idle, memory read, evaluate/commit
    gtsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // slot memory, limit register and result register
    gtsp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_result   (o_out.data)
    );

endmodule
